[sv/mop_pkg.sv]
// ----------------------------------------------------------------------------
// mop_pkg - shared types and constants for the MADT override parser
// Transfer payloads, status codes, record type codes and the structs that
// pass between the record parser, the override store and the top level.
// ----------------------------------------------------------------------------
package mop_pkg;

	// Request kinds
	localparam logic REQ_BYTE   = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Answer kinds
	localparam logic ANS_PARSE  = 1'b0;
	localparam logic ANS_LOOKUP = 1'b1;

	// Record type codes and length limits
	localparam logic [7:0] TYPE_IO_APIC  = 8'd1;
	localparam logic [7:0] TYPE_OVERRIDE = 8'd2;
	localparam logic [7:0] REC_MIN_LEN   = 8'd2;
	localparam logic [7:0] FIELD_LEN     = 8'd8;

	// Record offsets
	localparam logic [7:0] POS_TYPE   = 8'd0;
	localparam logic [7:0] POS_LENGTH = 8'd1;
	localparam logic [7:0] POS_BUS    = 8'd2;
	localparam logic [7:0] POS_SRC    = 8'd3;
	localparam logic [7:0] POS_WORD   = 8'd4;
	localparam logic [7:0] POS_WORD_L = 8'd7;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_LOADED = 2'd1,
		ST_IRQ_RANGE  = 2'd2,
		ST_MALFORMED  = 2'd3
	} status_t;

	typedef struct packed {
		logic       req_type;
		logic [7:0] table_byte;
		logic       last_byte;
		logic [7:0] irq_number;
	} req_t;

	typedef struct packed {
		logic        answer_kind;
		logic [31:0] global_irq;
		logic        overridden;
		logic [31:0] ioapic_base;
		logic        ioapic_found;
		status_t     status;
	} rsp_t;

	// Override store write request
	typedef struct packed {
		logic        we;
		logic [7:0]  irq;
		logic [31:0] gsi;
	} ovr_wr_t;

	// Parser status toward the top level
	typedef struct packed {
		logic        table_done;
		logic        ioapic_found;
		logic [31:0] ioapic_base;
		logic        malformed_next;
	} psr_stat_t;

endpackage

[sv/mop_parser.sv]
// ----------------------------------------------------------------------------
// mop_parser - byte-wise record parser
// Tracks the position inside the current record, gathers bus, source IRQ and
// the 32-bit word, and commits I/O APIC and override records at their end.
// ----------------------------------------------------------------------------
module mop_parser #(
	parameter int IRQ_SLOTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         table_byte,
	input  logic               last_byte,
	output mop_pkg::ovr_wr_t   wr,
	output mop_pkg::psr_stat_t stat
);

	logic [7:0]  pos_q, pos_d;
	logic [7:0]  kind_q, kind_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  bus_q, bus_d;
	logic [7:0]  src_q, src_d;
	logic [31:0] acc_q, acc_d;
	logic        malformed_q, malformed_d;
	logic        done_q, done_d;
	logic [31:0] ioapic_q, ioapic_d;
	logic        seen_q, seen_d;
	logic        commit;
	logic        src_in_range;

	assign src_in_range = {1'b0, src_d} < 9'(IRQ_SLOTS);

	always_comb begin
		pos_d       = pos_q;
		kind_d      = kind_q;
		len_d       = len_q;
		bus_d       = bus_q;
		src_d       = src_q;
		acc_d       = acc_q;
		malformed_d = malformed_q;
		done_d      = done_q;
		commit      = 1'b0;
		if (take && !malformed_q) begin
			if (pos_q == mop_pkg::POS_TYPE) begin
				kind_d = table_byte;
				acc_d  = '0;
				bus_d  = '0;
				src_d  = '0;
				pos_d  = mop_pkg::POS_LENGTH;
			end else if (pos_q == mop_pkg::POS_LENGTH) begin
				len_d = table_byte;
				if (table_byte < mop_pkg::REC_MIN_LEN ||
				    ((kind_q == mop_pkg::TYPE_IO_APIC || kind_q == mop_pkg::TYPE_OVERRIDE) &&
				     table_byte < mop_pkg::FIELD_LEN)) begin
					malformed_d = 1'b1;
					pos_d       = mop_pkg::POS_TYPE;
				end else if (table_byte == mop_pkg::REC_MIN_LEN) begin
					commit = 1'b1;
					pos_d  = mop_pkg::POS_TYPE;
				end else begin
					pos_d = mop_pkg::POS_BUS;
				end
			end else begin
				if (pos_q == mop_pkg::POS_BUS) begin
					bus_d = table_byte;
				end else if (pos_q == mop_pkg::POS_SRC) begin
					src_d = table_byte;
				end else if (pos_q inside {[mop_pkg::POS_WORD:mop_pkg::POS_WORD_L]}) begin
					acc_d[{pos_q[1:0], 3'b000} +: 8] = table_byte;
				end
				if ({1'b0, pos_q} + 9'd1 >= {1'b0, len_q}) begin
					commit = 1'b1;
					pos_d  = mop_pkg::POS_TYPE;
				end else begin
					pos_d = pos_q + 8'd1;
				end
			end
		end
		// An unfinished record at the end of the table counts as malformed
		if (take && last_byte) begin
			if (pos_d != mop_pkg::POS_TYPE) begin
				malformed_d = 1'b1;
				pos_d       = mop_pkg::POS_TYPE;
			end
			done_d = 1'b1;
		end
	end

	always_comb begin
		ioapic_d = ioapic_q;
		seen_d   = seen_q;
		wr.we    = 1'b0;
		wr.irq   = src_d;
		wr.gsi   = acc_d;
		if (commit) begin
			if (kind_d == mop_pkg::TYPE_IO_APIC) begin
				ioapic_d = acc_d;
				seen_d   = 1'b1;
			end else if (kind_d == mop_pkg::TYPE_OVERRIDE) begin
				wr.we = (bus_d == 8'd0) && src_in_range;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			kind_q      <= '0;
			len_q       <= '0;
			bus_q       <= '0;
			src_q       <= '0;
			acc_q       <= '0;
			malformed_q <= 1'b0;
			done_q      <= 1'b0;
			ioapic_q    <= '0;
			seen_q      <= 1'b0;
		end else begin
			pos_q       <= pos_d;
			kind_q      <= kind_d;
			len_q       <= len_d;
			bus_q       <= bus_d;
			src_q       <= src_d;
			acc_q       <= acc_d;
			malformed_q <= malformed_d;
			done_q      <= done_d;
			ioapic_q    <= ioapic_d;
			seen_q      <= seen_d;
		end
	end

	assign stat.table_done     = done_q;
	assign stat.ioapic_found   = seen_q;
	assign stat.ioapic_base    = ioapic_q;
	assign stat.malformed_next = malformed_d;

endmodule

[sv/mop_ovr_store.sv]
// ----------------------------------------------------------------------------
// mop_ovr_store - override store
// One synchronous memory of global interrupt numbers per legacy IRQ, with a
// valid bit per entry in flops; read data is registered.
// ----------------------------------------------------------------------------
module mop_ovr_store #(
	parameter int IRQ_SLOTS = 16,
	parameter int IDX_W     = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  mop_pkg::ovr_wr_t wr,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_idx,
	output logic [31:0]      rd_gsi,
	output logic             rd_hit
);

	logic [31:0]          mem_q [IRQ_SLOTS];
	logic [IRQ_SLOTS-1:0] valid_q;
	logic [31:0]          rd_gsi_q;
	logic                 rd_hit_q;
	logic [IDX_W-1:0]     wr_idx;

	assign wr_idx = wr.irq[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr_idx] <= wr.gsi;
		end
		if (rd_en) begin
			rd_gsi_q <= mem_q[rd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (wr.we) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_hit_q <= valid_q[rd_idx];
			end
		end
	end

	assign rd_gsi = rd_gsi_q;
	assign rd_hit = rd_hit_q;

endmodule

[sv/madt_override_parser.sv]
// ----------------------------------------------------------------------------
// madt_override_parser - MADT entry-area parser with IRQ override lookup
// Pipeline: a request transfer is registered into the result stage, where
// the override store read lands, and then into the output register.
// Throughput: one request per cycle; table bytes that end no table give no
// result. Back-pressure on rsp holds the result stage and then req_ready.
// Reset: arst_n clears parser state, valid bits and handshakes at once; the
// override memory contents are not cleared, an entry reads only when valid.
// ----------------------------------------------------------------------------
module madt_override_parser #(
	parameter int IRQ_SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  mop_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mop_pkg::rsp_t rsp
);

	localparam int IDX_W = (IRQ_SLOTS > 1) ? $clog2(IRQ_SLOTS) : 1;

	mop_pkg::ovr_wr_t   wr;
	mop_pkg::psr_stat_t stat;

	logic             req_fire;
	logic             byte_take;
	logic             lookup_fire;
	logic             irq_in_range;
	logic             has_result;
	logic [31:0]      rd_gsi;
	logic             rd_hit;

	// Result stage: the transfer has been taken and the store read issued
	logic             valid_s1;
	logic             kind_s1;
	mop_pkg::status_t status_s1;
	logic [7:0]       irq_s1;
	logic             adv_s1;
	mop_pkg::status_t status_new;

	logic             rsp_valid_q;
	mop_pkg::rsp_t    rsp_q;
	mop_pkg::rsp_t    rsp_d;

	// Advance the result stage whenever the output register is free or draining
	assign adv_s1      = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready   = !valid_s1 || adv_s1;
	assign req_fire    = req_valid && req_ready;
	assign irq_in_range = {1'b0, req.irq_number} < 9'(IRQ_SLOTS);

	// Drop table bytes once the table has ended
	assign byte_take   = req_fire && (req.req_type == mop_pkg::REQ_BYTE) && !stat.table_done;
	assign lookup_fire = req_fire && (req.req_type == mop_pkg::REQ_LOOKUP);
	assign has_result  = lookup_fire || (byte_take && req.last_byte);

	mop_parser #(
		.IRQ_SLOTS(IRQ_SLOTS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (byte_take),
		.table_byte(req.table_byte),
		.last_byte (req.last_byte),
		.wr        (wr),
		.stat      (stat)
	);

	mop_ovr_store #(
		.IRQ_SLOTS(IRQ_SLOTS),
		.IDX_W    (IDX_W)
	) u_store (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (wr),
		.rd_en (lookup_fire && irq_in_range),
		.rd_idx(req.irq_number[IDX_W-1:0]),
		.rd_gsi(rd_gsi),
		.rd_hit(rd_hit)
	);

	// Status is settled at transfer time: range check first, then table state
	always_comb begin
		if (req.req_type == mop_pkg::REQ_LOOKUP) begin
			if (!irq_in_range) begin
				status_new = mop_pkg::ST_IRQ_RANGE;
			end else if (!stat.table_done) begin
				status_new = mop_pkg::ST_NOT_LOADED;
			end else begin
				status_new = mop_pkg::ST_OK;
			end
		end else begin
			status_new = stat.malformed_next ? mop_pkg::ST_MALFORMED : mop_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_fire || adv_s1) begin
			valid_s1 <= req_fire && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			kind_s1   <= req.req_type;
			status_s1 <= status_new;
			irq_s1    <= req.irq_number;
		end
	end

	// Build the result; the parser registers already hold post-commit values
	always_comb begin
		rsp_d              = '0;
		rsp_d.answer_kind  = kind_s1;
		rsp_d.status       = status_s1;
		if (kind_s1 == mop_pkg::ANS_PARSE) begin
			rsp_d.ioapic_base  = stat.ioapic_base;
			rsp_d.ioapic_found = stat.ioapic_found;
		end else if (status_s1 == mop_pkg::ST_OK) begin
			rsp_d.ioapic_base  = stat.ioapic_base;
			rsp_d.ioapic_found = stat.ioapic_found;
			rsp_d.overridden   = rd_hit;
			rsp_d.global_irq   = rd_hit ? rd_gsi : {24'd0, irq_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	// The store is written only while the table is still being parsed
	a_no_write_after_table: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> !stat.table_done)
		else $error("override store written after table end");

	// Once the table has ended it stays ended
	a_table_done_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stat.table_done |=> stat.table_done)
		else $error("table_done dropped without reset");

	// A stalled result stage keeps its entry
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv_s1) |=> valid_s1)
		else $error("result stage lost an entry under stall");

	// The final table byte always yields a parse result in the next stage
	a_last_byte_result: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_take && req.last_byte) |=> (valid_s1 && kind_s1 == mop_pkg::ANS_PARSE))
		else $error("final table byte produced no parse result");

	// Overrides are reported only in successful lookups
	a_override_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.overridden) |->
			(rsp.answer_kind == mop_pkg::ANS_LOOKUP && rsp.status == mop_pkg::ST_OK))
		else $error("override flagged outside a good lookup");
`endif

endmodule

[test/madt_answer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// madt_answer_checker - answer predictor and scoreboard for the MADT parser
// Watches both channels, parses each accepted table byte up to the table end
// into its own copy of the record state and override slots, queues the
// expected answers and compares each returned answer field by field to the oldest.
// ----------------------------------------------------------------------------
module madt_answer_checker #(
	parameter int IRQ_SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  mop_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  mop_pkg::rsp_t rsp,
	output int            mismatches,
	output int            pending
);
	import mop_pkg::*;

	logic        slot_valid [IRQ_SLOTS];
	logic [31:0] slot_gsi   [IRQ_SLOTS];
	logic [31:0] apic_base;
	logic        apic_seen;
	logic        table_closed;
	logic        table_bad;
	logic [7:0]  rec_pos;
	logic [7:0]  rec_kind;
	logic [7:0]  rec_len;
	logic [7:0]  rec_bus;
	logic [7:0]  rec_src;
	logic [31:0] rec_word;
	rsp_t        answer_q [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < 100) begin
			$display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
		end
		mismatches++;
	endtask

	function automatic void commit_entry();
		if (rec_kind == TYPE_IO_APIC) begin
			apic_base = rec_word;
			apic_seen = 1'b1;
		end else if (rec_kind == TYPE_OVERRIDE && rec_bus == 8'd0 && rec_src < IRQ_SLOTS) begin
			slot_valid[rec_src] = 1'b1;
			slot_gsi[rec_src]   = rec_word;
		end
	endfunction

	function automatic void parse_entry_byte(input logic [7:0] b);
		if (table_bad) begin
			return;
		end
		if (rec_pos == POS_TYPE) begin
			rec_kind = b;
			rec_word = '0;
			rec_bus  = '0;
			rec_src  = '0;
			rec_pos  = POS_LENGTH;
		end else if (rec_pos == POS_LENGTH) begin
			rec_len = b;
			if (b < REC_MIN_LEN ||
					((rec_kind == TYPE_IO_APIC || rec_kind == TYPE_OVERRIDE) && b < FIELD_LEN)) begin
				table_bad = 1'b1;
				rec_pos   = POS_TYPE;
			end else if (b == REC_MIN_LEN) begin
				commit_entry();
				rec_pos = POS_TYPE;
			end else begin
				rec_pos = POS_BUS;
			end
		end else begin
			if (rec_pos == POS_BUS) begin
				rec_bus = b;
			end else if (rec_pos == POS_SRC) begin
				rec_src = b;
			end else if (rec_pos >= POS_WORD && rec_pos <= POS_WORD_L) begin
				rec_word[8 * (rec_pos - POS_WORD) +: 8] = b;
			end
			if ({1'b0, rec_pos} + 9'd1 >= {1'b0, rec_len}) begin
				commit_entry();
				rec_pos = POS_TYPE;
			end else begin
				rec_pos = rec_pos + 8'd1;
			end
		end
	endfunction

	function automatic void predict_answer(input req_t r);
		rsp_t a;
		a = '0;
		if (r.req_type == REQ_BYTE) begin
			if (table_closed) begin
				return;
			end
			parse_entry_byte(r.table_byte);
			if (!r.last_byte) begin
				return;
			end
			// a record still open at the end of the table counts as malformed
			if (rec_pos != POS_TYPE) begin
				table_bad = 1'b1;
				rec_pos   = POS_TYPE;
			end
			table_closed   = 1'b1;
			a.answer_kind  = ANS_PARSE;
			a.ioapic_base  = apic_base;
			a.ioapic_found = apic_seen;
			a.status       = table_bad ? ST_MALFORMED : ST_OK;
		end else if (r.irq_number >= IRQ_SLOTS) begin
			a.answer_kind = ANS_LOOKUP;
			a.status      = ST_IRQ_RANGE;
		end else if (!table_closed) begin
			a.answer_kind = ANS_LOOKUP;
			a.status      = ST_NOT_LOADED;
		end else begin
			a.answer_kind  = ANS_LOOKUP;
			a.ioapic_base  = apic_base;
			a.ioapic_found = apic_seen;
			a.status       = ST_OK;
			if (slot_valid[r.irq_number]) begin
				a.global_irq = slot_gsi[r.irq_number];
				a.overridden = 1'b1;
			end else begin
				a.global_irq = {24'd0, r.irq_number};
			end
		end
		answer_q.push_back(a);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		rsp_t want;
		if (!arst_n) begin
			foreach (slot_valid[i]) begin
				slot_valid[i] = 1'b0;
				slot_gsi[i]   = '0;
			end
			apic_base    = '0;
			apic_seen    = 1'b0;
			table_closed = 1'b0;
			table_bad    = 1'b0;
			rec_pos      = POS_TYPE;
			rec_kind     = '0;
			rec_len      = '0;
			rec_bus      = '0;
			rec_src      = '0;
			rec_word     = '0;
			mismatches   = 0;
			answer_q.delete();
			pending <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (answer_q.size() == 0) begin
					report_mismatch("unexpected answer, global_irq", rsp.global_irq, '0);
				end else begin
					want = answer_q.pop_front();
					if (rsp.answer_kind !== want.answer_kind)
						report_mismatch("answer_kind", rsp.answer_kind, want.answer_kind);
					if (rsp.global_irq !== want.global_irq)
						report_mismatch("global_irq", rsp.global_irq, want.global_irq);
					if (rsp.overridden !== want.overridden)
						report_mismatch("overridden", rsp.overridden, want.overridden);
					if (rsp.ioapic_base !== want.ioapic_base)
						report_mismatch("ioapic_base", rsp.ioapic_base, want.ioapic_base);
					if (rsp.ioapic_found !== want.ioapic_found)
						report_mismatch("ioapic_found", rsp.ioapic_found, want.ioapic_found);
					if (rsp.status !== want.status)
						report_mismatch("status", rsp.status, want.status);
				end
			end
			if (req_valid && req_ready) begin
				predict_answer(req);
			end
			pending <= answer_q.size();
		end
	end

endmodule

[test/tb_madt_override_parser.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_madt_override_parser - stimulus and verdict for the MADT override parser
// Resets once, sends early lookups and hand-built records that open the table, then
// a long run of random well-formed records mixed with lookups, closing the table
// in one of several clean or malformed ways, then lookups and late bytes after
// the table. Sender bursts and receiver stalls vary throughout; the checker
// module predicts and compares every answer.
// ----------------------------------------------------------------------------
module tb_madt_override_parser;
	import mop_pkg::*;

	localparam int IRQ_SLOTS    = 16;
	localparam int HOLD_CYCLES  = 80;    // long receiver hold-off
	localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer on either channel
	localparam int TABLE_ITEMS  = 100;   // random table part, split around the long record
	localparam int POST_LOOKUPS = 30;
	localparam int SETTLE       = 20;

	// How the random table ends
	typedef enum {END_CLEAN, END_CUT, END_SHORT_LEN, END_NO_FIT} table_end_e;
	// Receiver stall patterns
	typedef enum {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY} ready_mode_e;

	logic clk;
	logic arst_n      = 1'b0;
	logic req_valid   = 1'b0;
	logic req_ready;
	req_t req         = '0;
	logic rsp_valid;
	logic rsp_ready   = 1'b0;
	rsp_t rsp;
	logic rsp_hold_go = 1'b0;

	int mismatches;
	int pending;
	int burst_left = 0;
	int items_sent = 0;

	madt_override_parser #(
		.IRQ_SLOTS(IRQ_SLOTS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	madt_answer_checker #(
		.IRQ_SLOTS(IRQ_SLOTS)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.mismatches(mismatches),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Offer one request and hold it until the transfer. Requests go out in
	// bursts; at the start of each burst, drop valid for a random gap (which
	// may be zero, so some bursts run back to back). This task never lowers
	// and raises valid in the same step.
	task automatic send_item(input req_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req       <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		items_sent++;
	endtask

	// One entry-area byte; the lookup field carries noise.
	task automatic send_byte(input logic [7:0] b, input logic last);
		req_t item;
		item.req_type   = REQ_BYTE;
		item.table_byte = b;
		item.last_byte  = last;
		item.irq_number = 8'($urandom);
		send_item(item);
	endtask

	// One lookup; the table fields carry noise.
	task automatic lookup(input logic [7:0] irq);
		req_t item;
		item.req_type   = REQ_LOOKUP;
		item.table_byte = 8'($urandom);
		item.last_byte  = 1'($urandom);
		item.irq_number = irq;
		send_item(item);
	endtask

	// Send a whole record: type, length, bus, source IRQ, 32-bit word
	// little-endian, then filler up to the length. A length below the minimum
	// still sends the two header bytes. When last_at is not negative, flag
	// that byte as the end of the table and stop there.
	task automatic send_record(input logic [7:0] kind, input logic [7:0] len,
			input logic [7:0] bus, input logic [7:0] src, input logic [31:0] word,
			input int last_at);
		int n;
		logic [7:0] b;
		n = (len < REC_MIN_LEN) ? 2 : int'(len);
		if (last_at >= 0 && last_at < n) begin
			n = last_at + 1;
		end
		for (int i = 0; i < n; i++) begin
			if (i == 0)
				b = kind;
			else if (i == 1)
				b = len;
			else if (i == 2)
				b = bus;
			else if (i == 3)
				b = src;
			else if (i < 8)
				b = word[8 * (i - 4) +: 8];
			else
				b = 8'($urandom);
			send_byte(b, i == last_at);
		end
	endtask

	// A well-formed record with random content: overrides (mostly on bus 0
	// for an in-range IRQ), some I/O APIC records, the rest other types.
	// Overrides now and then name another bus or an IRQ past the slots.
	task automatic random_record(input bit closes_table);
		int pick;
		logic [7:0] kind, len, bus, src;
		pick = $urandom_range(0, 19);
		bus  = 8'($urandom);
		src  = 8'($urandom);
		if (pick < 7) begin
			kind = TYPE_OVERRIDE;
			len  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8, 14)) : 8'd10;
			bus  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
			src  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, IRQ_SLOTS - 1));
		end else if (pick < 11) begin
			kind = TYPE_IO_APIC;
			len  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8, 16)) : 8'd12;
		end else begin
			kind = 8'($urandom);
			if (kind == TYPE_IO_APIC || kind == TYPE_OVERRIDE) begin
				kind = kind + 8'd2;
			end
			len = 8'($urandom_range(2, 16));
		end
		send_record(kind, len, bus, src, $urandom, closes_table ? int'(len) - 1 : -1);
	endtask

	// Random records with a lookup now and then; lookups before the table
	// ends must answer not-loaded or out-of-range.
	task automatic table_stretch(input int count);
		int start;
		start = items_sent;
		while (items_sent - start < count) begin
			if ($urandom_range(0, 4) == 0) begin
				lookup(($urandom_range(0, 1) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, IRQ_SLOTS - 1)));
			end else begin
				random_record(1'b0);
			end
		end
	endtask

	// Stop offering and wait until every expected answer is back.
	task automatic drain();
		req_valid  <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Receiver: runs stall patterns of random length, and once, when asked,
	// holds ready low for a long stretch so the block backs up into req_ready.
	initial begin : receiver
		ready_mode_e mode;
		int span;
		bit held;
		held = 1'b0;
		forever begin
			if (rsp_hold_go && !held) begin
				held = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(posedge clk);
					rsp_ready <= 1'b0;
				end
			end else begin
				mode = ready_mode_e'($urandom_range(0, 2));
				span = $urandom_range(8, 48);
				repeat (span) begin
					@(posedge clk);
					case (mode)
						RDY_ALWAYS: rsp_ready <= 1'b1;
						RDY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
						default:    rsp_ready <= ($urandom_range(0, 3) != 0);
					endcase
				end
			end
		end
	end

	// Watchdog: end the run if no transfer happens for too long.
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle = 0;
			else
				idle++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin : stimulus
		table_end_e ending;
		int pick;
		int lookups;
		logic [7:0] kind;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Early lookups: lowest and highest in-range IRQ, first and last
		// out-of-range IRQ.
		lookup(8'd0);
		lookup(8'(IRQ_SLOTS - 1));
		lookup(8'(IRQ_SLOTS));
		lookup(8'd255);
		// Minimal I/O APIC record with base zero, minimal override for the
		// top slot with an all-ones global interrupt, a header-only record
		// and an unknown type that is skipped by its length.
		send_record(TYPE_IO_APIC, FIELD_LEN, 8'd0, 8'd0, 32'h0000_0000, -1);
		send_record(TYPE_OVERRIDE, FIELD_LEN, 8'd0, 8'(IRQ_SLOTS - 1), 32'hFFFF_FFFF, -1);
		send_record(8'd0, REC_MIN_LEN, 8'd0, 8'd0, 32'h0, -1);
		send_record(8'hFF, 8'd3, 8'd0, 8'd0, 32'h0, -1);
		drain();

		// Random table with one record of the largest length in the middle.
		table_stretch(TABLE_ITEMS / 2);
		pick = $urandom_range(0, 2);
		if (pick == 0)
			kind = TYPE_IO_APIC;
		else if (pick == 1)
			kind = TYPE_OVERRIDE;
		else
			kind = 8'($urandom_range(3, 255));
		send_record(kind, 8'd255, 8'd0, 8'($urandom_range(0, IRQ_SLOTS - 1)), $urandom, -1);
		table_stretch(TABLE_ITEMS / 2);

		// Close the table: cleanly, cut off inside a record, or after a
		// record too short to parse. After a bad length, a good override
		// follows and must not take effect.
		pick   = $urandom_range(0, 4);
		ending = (pick > 3) ? END_CLEAN : table_end_e'(pick);
		case (ending)
			END_CUT: begin
				pick = $urandom_range(0, 2);
				kind = (pick == 0) ? TYPE_IO_APIC : (pick == 1) ? TYPE_OVERRIDE
					: 8'($urandom_range(3, 255));
				pick = $urandom_range(8, 12);
				send_record(kind, 8'(pick), 8'd0, 8'($urandom_range(0, IRQ_SLOTS - 1)),
					$urandom, $urandom_range(0, pick - 2));
			end
			END_SHORT_LEN, END_NO_FIT: begin
				if (ending == END_SHORT_LEN) begin
					send_record(8'($urandom), 8'($urandom_range(0, 1)), 8'd0, 8'd0, $urandom, -1);
				end else begin
					kind = ($urandom_range(0, 1) == 0) ? TYPE_IO_APIC : TYPE_OVERRIDE;
					send_record(kind, 8'($urandom_range(2, 7)), 8'd0, 8'd0, $urandom, -1);
				end
				send_record(TYPE_OVERRIDE, 8'd10, 8'd0, 8'($urandom_range(0, IRQ_SLOTS - 1)),
					$urandom, 9);
			end
			default: random_record(1'b1);
		endcase
		drain();

		// After the table: ask the receiver for its long hold-off while the
		// lookups keep coming, walk every slot, then random lookups with late
		// table bytes mixed in (these must be ignored).
		rsp_hold_go <= 1'b1;
		for (int i = 0; i < IRQ_SLOTS; i++) begin
			lookup(8'(i));
		end
		lookups = 0;
		while (lookups < POST_LOOKUPS) begin
			if ($urandom_range(0, 5) == 0) begin
				send_byte(8'($urandom), 1'($urandom));
			end else begin
				lookup(($urandom_range(0, 4) == 0) ? 8'($urandom)
					: 8'($urandom_range(0, IRQ_SLOTS - 1)));
				lookups++;
			end
		end
		drain();

		// Let any stray answer show up before the verdict.
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
